@@ sv/pgir_pkg.sv @@
package pgir_pkg;

   localparam int BYTE_W    = 8;
   localparam int GAP_W     = 8;
   localparam int BITIDX_W  = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 8;

   // opcodes of an input item
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_READ = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SYNC_GAP_MIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_GAP_MIN  = 2'd1;

   localparam logic [CSR_W-1:0] SYNC_GAP_RESET = 8'd8;
   localparam logic [CSR_W-1:0] ONE_GAP_RESET  = 8'd5;

   localparam logic [GAP_W-1:0]    GAP_MAX   = 8'hFF;
   localparam logic [BITIDX_W-1:0] BYTE_BITS = 4'd8;

   typedef struct packed {
      logic [GAP_W-1:0]    gap_count;
      logic [BITIDX_W-1:0] bit_index;
      logic [BYTE_W-1:0]   shift_byte;
      logic                resync_wait;
      logic [BYTE_W-1:0]   last_byte;
   } chan_state_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } push_type;

   typedef struct packed {
      logic       en;
      logic [2:0] chan;
   } pop_req_type;

endpackage

@@ sv/pgir_chan_unit.sv @@
module pgir_chan_unit
   import pgir_pkg::*;
#(
   parameter int CHANNELS = 6,
   parameter int CH_W     = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [CH_W-1:0]    rd_idx,
   input  logic               proc_vld,
   input  logic [CH_W-1:0]    proc_idx,
   input  logic               pulse,
   input  logic               resync,
   input  logic [CSR_W-1:0]   sync_min,
   input  logic [CSR_W-1:0]   one_min,
   output push_type           push
);

   chan_state_type            mem_ff [CHANNELS];
   logic [CHANNELS-1:0]       vld_ff;
   chan_state_type            rd_data_ff;
   logic                      rd_vld_ff;
   chan_state_type            cur;
   chan_state_type            nxt;

   // entries never written read as the reset state
   assign cur = rd_vld_ff ? rd_data_ff : '0;

   always_comb begin
      nxt = cur;
      push.valid = 1'b0;
      push.data  = cur.shift_byte;
      nxt.resync_wait = cur.resync_wait | resync;
      if (!pulse) begin
         if (cur.gap_count != GAP_MAX) begin
            nxt.gap_count = cur.gap_count + 1'b1;
         end
      end else begin
         if (cur.gap_count >= sync_min) begin
            nxt.bit_index   = '0;
            nxt.shift_byte  = '0;
            nxt.resync_wait = 1'b0;
         end else if (cur.gap_count >= one_min) begin
            if (cur.bit_index < BYTE_BITS) begin
               nxt.shift_byte = cur.shift_byte | (BYTE_W'(1) << cur.bit_index[2:0]);
            end
            nxt.bit_index = cur.bit_index + 1'b1;
         end else if (cur.gap_count != '0) begin
            nxt.bit_index = cur.bit_index + 1'b1;
         end
         nxt.gap_count = '0;
         // byte complete: store it unless it repeats the last one or a resync is pending
         if (nxt.bit_index == BYTE_BITS && !nxt.resync_wait) begin
            nxt.bit_index = '0;
            if (nxt.shift_byte != cur.last_byte) begin
               push.valid    = 1'b1;
               nxt.last_byte = nxt.shift_byte;
            end
         end
      end
      push.data = nxt.shift_byte;
      if (!proc_vld) begin
         push.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_idx];
         rd_vld_ff  <= vld_ff[rd_idx];
      end
      if (proc_vld) begin
         mem_ff[proc_idx] <= nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (proc_vld) begin
         vld_ff[proc_idx] <= 1'b1;
      end
   end

endmodule

@@ sv/pgir_ring_unit.sv @@
module pgir_ring_unit
   import pgir_pkg::*;
#(
   parameter int CHANNELS   = 6,
   parameter int RING_DEPTH = 16,
   parameter int CH_W       = 3,
   parameter int PTR_W      = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  push_type            push,
   input  logic [CH_W-1:0]     push_idx,
   input  pop_req_type         pop,
   output logic                pop_hit,
   output logic [BYTE_W-1:0]   pop_data,
   output logic [CHANNELS-1:0] ready_mask
);

   localparam int ADDR_W = $clog2(CHANNELS * RING_DEPTH);

   logic [BYTE_W-1:0]  ring_mem [CHANNELS * RING_DEPTH];
   logic [PTR_W-1:0]   head_ff [CHANNELS];
   logic [PTR_W-1:0]   tail_ff [CHANNELS];
   logic [BYTE_W-1:0]  pop_data_ff;
   logic [CH_W-1:0]    pop_idx;
   logic [PTR_W-1:0]   head_sel;
   logic [PTR_W-1:0]   tail_sel;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign pop_idx  = pop.chan[CH_W-1:0];
   assign head_sel = head_ff[push_idx];
   assign tail_sel = tail_ff[pop_idx];
   assign wr_addr  = ADDR_W'(int'(push_idx) * RING_DEPTH + int'(head_sel));
   assign rd_addr  = ADDR_W'(int'(pop_idx) * RING_DEPTH + int'(tail_sel));
   assign pop_hit  = ({1'b0, pop.chan} < 4'(CHANNELS)) && (head_ff[pop_idx] != tail_sel);
   assign pop_data = pop_data_ff;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         ready_mask[c] = head_ff[c] != tail_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         ring_mem[wr_addr] <= push.data;
      end
      if (pop.en && pop_hit) begin
         pop_data_ff <= ring_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            head_ff[c] <= '0;
            tail_ff[c] <= '0;
         end
      end else begin
         // overflow wraps head onto tail: the ring then reads as empty
         if (push.valid) begin
            head_ff[push_idx] <= ptr_next(head_sel);
         end
         if (pop.en && pop_hit) begin
            tail_ff[pop_idx] <= ptr_next(tail_sel);
         end
      end
   end

endmodule

@@ sv/pulse_gap_ir_receiver_unit.sv @@
// A sample tick passes through the ST_TICK and ST_DONE states before its result is
// registered; a read goes straight to ST_DONE. The block takes one item at a time and stalls
// the input until the item's result is loaded; during a tick the channel state memory is read
// and written back once per channel, one channel per cycle. Reset: synchronous, active high;
// clears channel state, ring pointers and the thresholds (sync 8, one 5). Ring contents are
// not cleared.
module pulse_gap_ir_receiver_unit
   import pgir_pkg::*;
#(
   parameter int CHANNELS   = 6,
   parameter int RING_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // input channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_opcode,
   input  logic [CHANNELS-1:0]  req_rx_lines,
   input  logic                 req_resync,
   input  logic [2:0]           req_channel,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BYTE_W-1:0]    rsp_read_data,
   output logic                 rsp_read_empty,
   output logic [CHANNELS-1:0]  rsp_ready_mask,
   // configuration
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W = $clog2(CHANNELS + 1);
   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TICK = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    iss_cnt_ff, iss_cnt_in;
   logic                proc_vld_ff, proc_vld_in;
   logic [CH_W-1:0]     proc_idx_ff;
   logic                is_read_ff;
   logic                hit_ff;
   logic [CHANNELS-1:0] lines_ff;
   logic                resync_ff;
   logic [CSR_W-1:0]    sync_min_ff;
   logic [CSR_W-1:0]    one_min_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_data_ff;
   logic                rsp_empty_ff;
   logic [CHANNELS-1:0] rsp_mask_ff;

   logic                req_xfer;
   logic                rsp_free;
   logic                rd_en;
   logic                finish;
   push_type            push;
   pop_req_type         pop;
   logic                pop_hit;
   logic [BYTE_W-1:0]   pop_data;
   logic [CHANNELS-1:0] ready_mask;

   // Take a new item only from idle. The output register decouples the result side,
   // so an item can be in flight while the previous result still waits.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = (state_ff == ST_DONE) && rsp_free;

   assign pop.en   = req_xfer && (req_opcode == OP_READ);
   assign pop.chan = req_channel;

   // Tick sequencer: issue one state read per channel, process each in the cycle after its
   // read and write it back. Distinct channels never collide, so no forwarding is needed.
   assign rd_en = (state_ff == ST_TICK) && (iss_cnt_ff != CNT_W'(CHANNELS));

   always_comb begin
      state_in    = state_ff;
      iss_cnt_in  = iss_cnt_ff;
      proc_vld_in = rd_en;
      case (state_ff)
         ST_IDLE: begin
            iss_cnt_in = '0;
            if (req_xfer) begin
               state_in = (req_opcode == OP_TICK) ? ST_TICK : ST_DONE;
            end
         end
         ST_TICK: begin
            if (rd_en) begin
               iss_cnt_in = iss_cnt_ff + 1'b1;
            end else if (!proc_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Drop the result after its transfer; load a fresh one when the item finishes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iss_cnt_ff   <= '0;
         proc_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sync_min_ff  <= SYNC_GAP_RESET;
         one_min_ff   <= ONE_GAP_RESET;
      end else begin
         state_ff     <= state_in;
         iss_cnt_ff   <= iss_cnt_in;
         proc_vld_ff  <= proc_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         // writes beyond the register list are ignored
         if (csr_we && csr_index == REG_SYNC_GAP_MIN) begin
            sync_min_ff <= csr_wdata;
         end
         if (csr_we && csr_index == REG_ONE_GAP_MIN) begin
            one_min_ff <= csr_wdata;
         end
      end
   end

   // Payload registers: hold the item fields and the result.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         is_read_ff <= (req_opcode == OP_READ);
         hit_ff     <= pop_hit;
         lines_ff   <= req_rx_lines;
         resync_ff  <= req_resync;
      end
      if (rd_en) begin
         proc_idx_ff <= iss_cnt_ff[CH_W-1:0];
      end
      if (finish) begin
         rsp_data_ff  <= (is_read_ff && hit_ff) ? pop_data : '0;
         rsp_empty_ff <= is_read_ff && !hit_ff;
         rsp_mask_ff  <= ready_mask;
      end
   end

   pgir_chan_unit #(
      .CHANNELS (CHANNELS),
      .CH_W     (CH_W)
   ) u_chan (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_idx   (iss_cnt_ff[CH_W-1:0]),
      .proc_vld (proc_vld_ff),
      .proc_idx (proc_idx_ff),
      .pulse    (lines_ff[proc_idx_ff]),
      .resync   (resync_ff),
      .sync_min (sync_min_ff),
      .one_min  (one_min_ff),
      .push     (push)
   );

   pgir_ring_unit #(
      .CHANNELS   (CHANNELS),
      .RING_DEPTH (RING_DEPTH),
      .CH_W       (CH_W),
      .PTR_W      (PTR_W)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_idx   (proc_idx_ff),
      .pop        (pop),
      .pop_hit    (pop_hit),
      .pop_data   (pop_data),
      .ready_mask (ready_mask)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_read_empty = rsp_empty_ff;
   assign rsp_ready_mask = rsp_mask_ff;

endmodule
